### sv/lav_pkg.sv
package lav_pkg;

	// Position of the leading one after a vector has been normalised.
	localparam int NORM_MSB = 29;

	// Fraction bits of the reciprocal square root datapath.
	localparam int Q30 = 30;

	// The constant three in Q30 for the Newton step.
	localparam logic [33:0] THREE_Q30 = 34'd3 << Q30;

	// Column code of the translation column.
	localparam logic [1:0] LAST_COL = 2'd3;

	// Reciprocal square root seeds, indexed by the top four bits of the Q30 sum.
	localparam logic [9:0] SEED_TAB [16] = '{
		10'd724, 10'd418, 10'd324, 10'd274, 10'd241, 10'd218, 10'd201, 10'd187,
		10'd176, 10'd166, 10'd158, 10'd151, 10'd151, 10'd151, 10'd151, 10'd151
	};

	// One finished matrix, held by the column serialiser.
	typedef struct packed {
		logic [2:0][31:0] rt;
		logic [2:0][31:0] up;
		logic [2:0][31:0] lk;
		logic [2:0][31:0] tr;
		logic             degen;
		logic             sat;
	} mat_t;

endpackage

### sv/lav_norm.sv
module lav_norm #(
	parameter int VW          = 33,
	parameter int SW          = 1,
	parameter int FRAC_BITS   = 16,
	parameter int RSQRT_ITERS = 3,
	parameter int OW          = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [VW-1:0] vec [3],
	input  logic [SW-1:0]        in_side,
	output logic                 out_vld,
	output logic                 out_nz,
	output logic signed [OW-1:0] u [3],
	output logic [SW-1:0]        out_side
);
	import lav_pkg::*;

	localparam int LPW = $clog2(VW);
	localparam int SH  = 60 - FRAC_BITS;

	typedef struct packed {
		logic [SW-1:0]    side;
		logic [2:0]       neg;
		logic             nz;
		logic [2:0][29:0] nm;
		logic [31:0]      a;
		logic [32:0]      y;
		logic [33:0]      w;
	} nrm_t;

	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	logic [VW-1:0]    mag_s1 [3];
	logic [VW-1:0]    mag_s2 [3];
	logic [SW-1:0]    side_s1, side_s2, side_s3, side_s4;
	logic [LPW-1:0]   lp_s2;
	logic             nz_s2, nz_s3, nz_s4;
	logic [2:0][29:0] nm_s3, nm_s4;
	logic [59:0]      sq_s4 [3];
	nrm_t             cr_s5;

	logic [VW-1:0]    orm;
	logic [LPW-1:0]   lp_c;
	logic [2:0][29:0] nm_c;
	logic [61:0]      ss;

	nrm_t ia_s [RSQRT_ITERS];
	nrm_t ib_s [RSQRT_ITERS];
	nrm_t ic_s [RSQRT_ITERS];
	logic va_s [RSQRT_ITERS];
	logic vb_s [RSQRT_ITERS];
	logic vc_s [RSQRT_ITERS];

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Leading one of the largest magnitude, found from the OR of all three.
	always_comb begin
		orm  = mag_s1[0] | mag_s1[1] | mag_s1[2];
		lp_c = '0;
		for (int j = 0; j < VW; j++) begin
			if (orm[j]) lp_c = LPW'(j);
		end
	end

	// Shift so that the leading one lands on bit 29; right shifts truncate.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lp_s2 >= LPW'(NORM_MSB)) begin
				nm_c[i] = 30'(mag_s2[i] >> (lp_s2 - LPW'(NORM_MSB)));
			end else begin
				nm_c[i] = 30'(mag_s2[i][29:0] << (LPW'(NORM_MSB) - lp_s2));
			end
		end
	end

	assign ss = 62'(sq_s4[0]) + 62'(sq_s4[1]) + 62'(sq_s4[2]);

	// Magnitudes, leading one, shift, squares and seed.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][VW-1];
				mag_s1[i] <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
				mag_s2[i] <= mag_s1[i];
				sq_s4[i]  <= 60'(nm_s3[i]) * 60'(nm_s3[i]);
			end
			side_s1 <= in_side;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			lp_s2   <= lp_c;
			nz_s2   <= |orm;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
			nz_s3   <= nz_s2;
			nm_s3   <= nm_c;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;
			nz_s4   <= nz_s3;
			nm_s4   <= nm_s3;
			cr_s5.side <= side_s4;
			cr_s5.neg  <= neg_s4;
			cr_s5.nz   <= nz_s4;
			cr_s5.nm   <= nm_s4;
			cr_s5.a    <= ss[61:30];
			cr_s5.y    <= 33'({SEED_TAB[ss[61:58]], 22'd0});
			cr_s5.w    <= '0;
		end
	end

	// Newton steps, three stages each: y squared, times a, then the update.
	for (genvar k = 0; k < RSQRT_ITERS; k++) begin : g_it
		nrm_t src, na, nb, nc;
		logic src_v;

		if (k == 0) begin : g_first
			assign src   = cr_s5;
			assign src_v = vld_s5;
		end else begin : g_next
			assign src   = ic_s[k-1];
			assign src_v = vc_s[k-1];
		end

		always_comb begin
			na   = src;
			na.w = 34'((64'(src.y) * 64'(src.y)) >> Q30);
		end

		always_comb begin
			nb   = ia_s[k];
			nb.w = 34'((64'(ia_s[k].a) * 64'(ia_s[k].w)) >> Q30);
		end

		always_comb begin
			logic [31:0] h;
			h    = (ib_s[k].w < THREE_Q30) ? 32'(THREE_Q30 - ib_s[k].w) : '0;
			nc   = ib_s[k];
			nc.y = 33'((64'(ib_s[k].y) * 64'(h)) >> 31);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va_s[k] <= 1'b0;
				vb_s[k] <= 1'b0;
				vc_s[k] <= 1'b0;
			end else if (en) begin
				va_s[k] <= src_v;
				vb_s[k] <= va_s[k];
				vc_s[k] <= vb_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ia_s[k] <= na;
				ib_s[k] <= nb;
				ic_s[k] <= nc;
			end
		end
	end

	// Scale each magnitude by the reciprocal length, round and restore the sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vc_s[RSQRT_ITERS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [63:0]   r64;
				logic [OW-1:0] rr;
				r64  = 64'(ic_s[RSQRT_ITERS-1].nm[i]) * 64'(ic_s[RSQRT_ITERS-1].y)
					+ (64'd1 << (SH - 1));
				rr   = OW'(r64 >> SH);
				u[i] <= ic_s[RSQRT_ITERS-1].neg[i] ? -rr : rr;
			end
			out_nz   <= ic_s[RSQRT_ITERS-1].nz;
			out_side <= ic_s[RSQRT_ITERS-1].side;
		end
	end

endmodule

### sv/lav_cross.sv
module lav_cross #(
	parameter int AW = 32,
	parameter int BW = 20,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic signed [AW-1:0]   a [3],
	input  logic signed [BW-1:0]   b [3],
	input  logic [SW-1:0]          in_side,
	output logic                   out_vld,
	output logic signed [AW+BW:0]  c [3],
	output logic [SW-1:0]          out_side
);
	localparam int PW = AW + BW;

	logic                 vld_s1;
	logic signed [PW-1:0] pr_s1 [6];
	logic [SW-1:0]        side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	// Six partial products, then the three differences.
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1[0] <= a[1] * b[2];
			pr_s1[1] <= a[2] * b[1];
			pr_s1[2] <= a[2] * b[0];
			pr_s1[3] <= a[0] * b[2];
			pr_s1[4] <= a[0] * b[1];
			pr_s1[5] <= a[1] * b[0];
			side_s1  <= in_side;
			for (int i = 0; i < 3; i++) begin
				c[i] <= (PW+1)'(pr_s1[2*i]) - (PW+1)'(pr_s1[2*i+1]);
			end
			out_side <= side_s1;
		end
	end

endmodule

### sv/lav_ser.sv
module lav_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  lav_pkg::mat_t      mat,
	output logic               ready,
	input  logic               stall,
	output logic               vld,
	output logic [1:0]         col,
	output logic signed [31:0] row0,
	output logic signed [31:0] row1,
	output logic signed [31:0] row2,
	output logic               last,
	output logic               degen,
	output logic               sat
);
	import lav_pkg::*;

	mat_t       mat_q;
	logic       busy_q;
	logic [1:0] col_q;

	// A new matrix may load while idle or once the last column is being transferred.
	assign ready = !busy_q || (!stall && col_q == LAST_COL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else if (in_vld && ready) begin
			busy_q <= 1'b1;
			col_q  <= '0;
		end else if (busy_q && !stall) begin
			if (col_q == LAST_COL) begin
				busy_q <= 1'b0;
			end
			col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld && ready) begin
			mat_q <= mat;
		end
	end

	// Column selection from the held matrix.
	always_comb begin
		unique case (col_q)
			2'd0: begin
				row0 = mat_q.rt[0];
				row1 = mat_q.up[0];
				row2 = mat_q.lk[0];
			end
			2'd1: begin
				row0 = mat_q.rt[1];
				row1 = mat_q.up[1];
				row2 = mat_q.lk[1];
			end
			2'd2: begin
				row0 = mat_q.rt[2];
				row1 = mat_q.up[2];
				row2 = mat_q.lk[2];
			end
			default: begin
				row0 = mat_q.tr[0];
				row1 = mat_q.tr[1];
				row2 = mat_q.tr[2];
			end
		endcase
	end

	assign vld   = busy_q;
	assign col   = col_q;
	assign last  = (col_q == LAST_COL);
	assign degen = mat_q.degen;
	assign sat   = mat_q.sat;

endmodule

### sv/look_at_view_matrix_unit.sv
// Left-handed look-at view matrix unit.
//
// Input channel (cam_valid / cam_stall): one transfer carries a camera
// position, a target point and a world-up hint, all signed fixed point with
// FRAC_BITS fraction bits. Output channel (col_valid / col_stall): each input
// produces four transfers, the matrix columns 0 to 3 in order; column 3 holds
// the saturated translations and carries last_column. The degenerate and
// saturated flags repeat on all four columns of a matrix.
//
// The first column appears once the input has passed the pipeline and the
// serialiser; the other three follow it in order. The serialiser sends
// the four columns of each matrix in turn, which limits the input rate;
// the pipeline itself takes an input every cycle unless it holds.
//
// Reset clears every valid bit and the serialiser; no output is shown until
// a new input has gone through. While col_stall is high the pipeline keeps
// filling until a finished matrix waits behind the serialiser, then the
// whole pipeline holds and cam_stall rises; nothing is dropped or repeated.
module look_at_view_matrix_unit #(
	parameter int FRAC_BITS   = 16,
	parameter int RSQRT_ITERS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cam_valid,
	output logic               cam_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] up_hint_x,
	input  logic signed [31:0] up_hint_y,
	input  logic signed [31:0] up_hint_z,
	output logic               col_valid,
	input  logic               col_stall,
	output logic [1:0]         column_index,
	output logic signed [31:0] entry_row0,
	output logic signed [31:0] entry_row1,
	output logic signed [31:0] entry_row2,
	output logic [16:0]        entry_row3,
	output logic               last_column,
	output logic               degenerate,
	output logic               saturated
);
	import lav_pkg::*;

	localparam int LW  = FRAC_BITS + 4;
	localparam int CW  = 33 + LW;
	localparam int UCW = 2 * LW + 1;
	localparam int UPW = 2 * LW + 2 - FRAC_BITS;
	localparam int DW  = 34 + UPW;
	localparam int SWL = 192;
	localparam int SWR = 96 + 3 * LW;
	localparam int SWX = 96 + 6 * LW + 1;
	localparam logic [16:0] ROW3_ONE = 17'((64'd1 << FRAC_BITS) & 64'h1FFFF);

	// Negate, round and clip one dot product; the top bit flags a clip.
	function automatic logic [32:0] neg_round_sat(input logic signed [DW-1:0] dot);
		logic signed [DW:0] nd;
		logic signed [DW:0] half;
		logic signed [DW:0] sum;
		logic signed [DW:0] rn;
		logic               hi;
		logic               lo;
		half = '0;
		half[FRAC_BITS-1] = 1'b1;
		nd  = -((DW+1)'(dot));
		sum = nd + half;
		rn  = sum >>> FRAC_BITS;
		hi  = !rn[DW] && (|rn[DW-1:31]);
		lo  = rn[DW] && !(&rn[DW-1:31]);
		return {hi | lo, hi ? 32'h7FFF_FFFF : (lo ? 32'h8000_0000 : rn[31:0])};
	endfunction

	logic en;
	logic ser_rdy;

	// Stage 1: input register and look direction.
	logic              vld_s1;
	logic signed [31:0] p_s1 [3];
	logic signed [31:0] h_s1 [3];
	logic signed [32:0] d_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cam_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= pos_x;
			p_s1[1] <= pos_y;
			p_s1[2] <= pos_z;
			h_s1[0] <= up_hint_x;
			h_s1[1] <= up_hint_y;
			h_s1[2] <= up_hint_z;
			d_s1[0] <= 33'(target_x) - 33'(pos_x);
			d_s1[1] <= 33'(target_y) - 33'(pos_y);
			d_s1[2] <= 33'(target_z) - 33'(pos_z);
		end
	end

	// Look axis.
	logic [SWL-1:0]     side_li, side_lo;
	logic               vld_l;
	logic signed [LW-1:0] lk_l [3];
	logic signed [31:0] h_l [3];

	assign side_li = {p_s1[0], p_s1[1], p_s1[2], h_s1[0], h_s1[1], h_s1[2]};

	lav_norm #(
		.VW(33), .SW(SWL), .FRAC_BITS(FRAC_BITS), .RSQRT_ITERS(RSQRT_ITERS), .OW(LW)
	) u_norm_look (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s1), .vec(d_s1),
		.in_side(side_li), .out_vld(vld_l), .out_nz(), .u(lk_l), .out_side(side_lo)
	);

	// Cross of up hint and look.
	logic [SWR-1:0]       side_x1, side_c1;
	logic                 vld_c1;
	logic signed [CW-1:0] rc [3];

	always_comb begin
		side_x1[SWR-1 -: 96] = side_lo[SWL-1 -: 96];
		for (int i = 0; i < 3; i++) begin
			h_l[i] = side_lo[95-32*i -: 32];
			side_x1[3*LW-1-LW*i -: LW] = lk_l[i];
		end
	end

	lav_cross #(.AW(32), .BW(LW), .SW(SWR)) u_cross_right (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_l), .a(h_l), .b(lk_l),
		.in_side(side_x1), .out_vld(vld_c1), .c(rc), .out_side(side_c1)
	);

	// Right axis.
	logic [SWR-1:0]       side_r;
	logic                 vld_r;
	logic                 nz_r;
	logic signed [LW-1:0] rt_r [3];
	logic signed [LW-1:0] lk_z [3];

	lav_norm #(
		.VW(CW), .SW(SWR), .FRAC_BITS(FRAC_BITS), .RSQRT_ITERS(RSQRT_ITERS), .OW(LW)
	) u_norm_right (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_c1), .vec(rc),
		.in_side(side_c1), .out_vld(vld_r), .out_nz(nz_r), .u(rt_r), .out_side(side_r)
	);

	// A zero cross product clears the look axis as well.
	logic [SWX-1:0] side_x2, side_c2;

	always_comb begin
		side_x2[SWX-1 -: 96] = side_r[SWR-1 -: 96];
		for (int i = 0; i < 3; i++) begin
			lk_z[i] = nz_r ? LW'(side_r[3*LW-1-LW*i -: LW]) : '0;
			side_x2[6*LW-LW*i -: LW] = lk_z[i];
			side_x2[3*LW-LW*i -: LW] = rt_r[i];
		end
		side_x2[0] = !nz_r;
	end

	// Cross of look and right.
	logic                  vld_c2;
	logic signed [UCW-1:0] uc [3];

	lav_cross #(.AW(LW), .BW(LW), .SW(SWX)) u_cross_up (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_r), .a(lk_z), .b(rt_r),
		.in_side(side_x2), .out_vld(vld_c2), .c(uc), .out_side(side_c2)
	);

	// Stage U: round the up axis.
	logic                  vld_u;
	logic                  degen_u;
	logic signed [31:0]    p_u [3];
	logic signed [LW-1:0]  lk_u [3];
	logic signed [LW-1:0]  rt_u [3];
	logic signed [UPW-1:0] up_u [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_u <= 1'b0;
		end else if (en) begin
			vld_u <= vld_c2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [UCW:0] half;
				logic signed [UCW:0] ur;
				half = '0;
				half[FRAC_BITS-1] = 1'b1;
				ur = (UCW+1)'(uc[i]) + half;
				up_u[i] <= UPW'(ur >>> FRAC_BITS);
				p_u[i]  <= side_c2[SWX-1-32*i -: 32];
				lk_u[i] <= side_c2[6*LW-LW*i -: LW];
				rt_u[i] <= side_c2[3*LW-LW*i -: LW];
			end
			degen_u <= side_c2[0];
		end
	end

	// Stage T1: products of the position with each axis.
	logic                       vld_t1;
	logic                       degen_t1;
	logic signed [32+LW-1:0]    prr_t1 [3];
	logic signed [32+UPW-1:0]   pru_t1 [3];
	logic signed [32+LW-1:0]    prl_t1 [3];
	logic [2:0][31:0]           rt_t1, up_t1, lk_t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t1 <= 1'b0;
		end else if (en) begin
			vld_t1 <= vld_u;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prr_t1[i] <= p_u[i] * rt_u[i];
				pru_t1[i] <= p_u[i] * up_u[i];
				prl_t1[i] <= p_u[i] * lk_u[i];
				rt_t1[i]  <= 32'(rt_u[i]);
				up_t1[i]  <= 32'(up_u[i]);
				lk_t1[i]  <= 32'(lk_u[i]);
			end
			degen_t1 <= degen_u;
		end
	end

	// Stage T2: dot sums, negation, rounding and clipping.
	logic        vld_t2;
	mat_t        mat_t2;
	logic [32:0] trx, try_, trz;

	assign trx  = neg_round_sat(DW'(prr_t1[0]) + DW'(prr_t1[1]) + DW'(prr_t1[2]));
	assign try_ = neg_round_sat(DW'(pru_t1[0]) + DW'(pru_t1[1]) + DW'(pru_t1[2]));
	assign trz  = neg_round_sat(DW'(prl_t1[0]) + DW'(prl_t1[1]) + DW'(prl_t1[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t2 <= 1'b0;
		end else if (en) begin
			vld_t2 <= vld_t1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_t2.rt    <= rt_t1;
			mat_t2.up    <= up_t1;
			mat_t2.lk    <= lk_t1;
			mat_t2.tr[0] <= trx[31:0];
			mat_t2.tr[1] <= try_[31:0];
			mat_t2.tr[2] <= trz[31:0];
			mat_t2.degen <= degen_t1;
			mat_t2.sat   <= trx[32] | try_[32] | trz[32];
		end
	end

	// The pipeline moves unless a finished matrix waits on the serialiser.
	assign en        = !vld_t2 || ser_rdy;
	assign cam_stall = !en;

	lav_ser u_ser (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_t2), .mat(mat_t2), .ready(ser_rdy),
		.stall(col_stall), .vld(col_valid), .col(column_index), .row0(entry_row0),
		.row1(entry_row1), .row2(entry_row2), .last(last_column), .degen(degenerate),
		.sat(saturated)
	);

	assign entry_row3 = last_column ? ROW3_ONE : '0;

endmodule

### sv/lav_chk.sv
module lav_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        col_valid,
	input logic        col_stall,
	input logic [1:0]  column_index,
	input logic [31:0] entry_row0,
	input logic [16:0] entry_row3,
	input logic        last_column,
	input logic        degenerate,
	input logic        saturated
);
	import lav_pkg::*;

	// The last column flag marks the translation column and no other.
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		col_valid |-> (last_column == (column_index == LAST_COL)))
		else $error("last_column does not match column_index");

	// Only the translation column carries the homogeneous one.
	a_row3_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(col_valid && !last_column) |-> (entry_row3 == '0))
		else $error("entry_row3 nonzero on an axis column");

	// After an axis column transfer the next column follows at once.
	a_col_next: assert property (@(posedge clk) disable iff (!arst_n)
		(col_valid && !col_stall && !last_column) |=>
		(col_valid && column_index == $past(column_index) + 2'd1))
		else $error("column sequence broken");

	// Zero axes give zero translations, which cannot clip.
	a_degen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(col_valid && degenerate) |-> !saturated)
		else $error("saturated set on a degenerate matrix");

	// A stalled column holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(col_valid && col_stall) |=>
		(col_valid && $stable(column_index) && $stable(entry_row0)))
		else $error("stalled column changed");

endmodule

bind look_at_view_matrix_unit lav_chk u_lav_chk (.*);
